### design/psd_pkg.sv
// shared constants and types for the point to segment distance core
`default_nettype none
package psd_pkg;
  localparam int IN_W       = 16;
  localparam int IN_DATA_W  = 6 * IN_W;
  localparam int DIST_W     = 25;
  localparam int OUT_DATA_W = 32;
  localparam int USER_W     = 3;

  localparam logic [1:0] REGION_BEFORE  = 2'd0;
  localparam logic [1:0] REGION_BETWEEN = 2'd1;
  localparam logic [1:0] REGION_BEYOND  = 2'd2;

  typedef struct packed {
    logic       degen;
    logic [1:0] region;
  } psd_tag_t;
endpackage
`default_nettype wire

### design/psd_front.sv
// front pipeline: differences, products, region decision and dividend setup
`default_nettype none
module psd_front #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 8,
  localparam int LW = 2 * COORD_BITS + 2,
  localparam int QW = 2 * COORD_BITS + 3 + 2 * FRAC_BITS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic                          valid_i,
  input  wire logic signed [psd_pkg::IN_W-1:0] px_i,
  input  wire logic signed [psd_pkg::IN_W-1:0] py_i,
  input  wire logic signed [psd_pkg::IN_W-1:0] ax_i,
  input  wire logic signed [psd_pkg::IN_W-1:0] ay_i,
  input  wire logic signed [psd_pkg::IN_W-1:0] bx_i,
  input  wire logic signed [psd_pkg::IN_W-1:0] by_i,
  output logic                               valid_o,
  output logic [LW-1:0]                      rem_o,
  output logic [QW-1:0]                      rest_o,
  output logic [LW-1:0]                      div_o,
  output psd_pkg::psd_tag_t                  tag_o
);
  import psd_pkg::*;

  localparam int EW = (COORD_BITS > IN_W) ? COORD_BITS : IN_W;
  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * COORD_BITS + 2;
  localparam int SW = 2 * COORD_BITS + 3;
  localparam int TW = SW + 1;
  localparam int HW = COORD_BITS + 1;
  localparam int CW = 2 * HW;
  localparam int NW = 2 * CW + 2 * FRAC_BITS;

  logic signed [IN_W-1:0]       raw [6];
  logic signed [EW-1:0]         ext [6];
  logic signed [COORD_BITS-1:0] crd [6];

  assign raw[0] = px_i;
  assign raw[1] = py_i;
  assign raw[2] = ax_i;
  assign raw[3] = ay_i;
  assign raw[4] = bx_i;
  assign raw[5] = by_i;

  for (genvar g = 0; g < 6; g++) begin : g_sext
    assign ext[g] = EW'(raw[g]);
    assign crd[g] = ext[g][COORD_BITS-1:0];
  end

  // stage 1: coordinate differences
  logic                 s1_vld_q;
  logic signed [DW-1:0] s1_abx_q, s1_aby_q, s1_apx_q, s1_apy_q, s1_bpx_q, s1_bpy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en_i) begin
      s1_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_abx_q <= DW'(crd[4]) - DW'(crd[2]);
      s1_aby_q <= DW'(crd[5]) - DW'(crd[3]);
      s1_apx_q <= DW'(crd[0]) - DW'(crd[2]);
      s1_apy_q <= DW'(crd[1]) - DW'(crd[3]);
      s1_bpx_q <= DW'(crd[0]) - DW'(crd[4]);
      s1_bpy_q <= DW'(crd[1]) - DW'(crd[5]);
    end
  end

  // stage 2: all products
  logic                 s2_vld_q, s2_degen_q;
  logic signed [PW-1:0] s2_abx_apx_q, s2_aby_apy_q, s2_abx_bpx_q, s2_aby_bpy_q;
  logic signed [PW-1:0] s2_abx_apy_q, s2_aby_apx_q;
  logic signed [PW-1:0] s2_abx_sq_q, s2_aby_sq_q, s2_apx_sq_q, s2_apy_sq_q;
  logic signed [PW-1:0] s2_bpx_sq_q, s2_bpy_sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (en_i) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_degen_q   <= (s1_abx_q == '0) && (s1_aby_q == '0);
      s2_abx_apx_q <= PW'(s1_abx_q) * PW'(s1_apx_q);
      s2_aby_apy_q <= PW'(s1_aby_q) * PW'(s1_apy_q);
      s2_abx_bpx_q <= PW'(s1_abx_q) * PW'(s1_bpx_q);
      s2_aby_bpy_q <= PW'(s1_aby_q) * PW'(s1_bpy_q);
      s2_abx_apy_q <= PW'(s1_abx_q) * PW'(s1_apy_q);
      s2_aby_apx_q <= PW'(s1_aby_q) * PW'(s1_apx_q);
      s2_abx_sq_q  <= PW'(s1_abx_q) * PW'(s1_abx_q);
      s2_aby_sq_q  <= PW'(s1_aby_q) * PW'(s1_aby_q);
      s2_apx_sq_q  <= PW'(s1_apx_q) * PW'(s1_apx_q);
      s2_apy_sq_q  <= PW'(s1_apy_q) * PW'(s1_apy_q);
      s2_bpx_sq_q  <= PW'(s1_bpx_q) * PW'(s1_bpx_q);
      s2_bpy_sq_q  <= PW'(s1_bpy_q) * PW'(s1_bpy_q);
    end
  end

  // stage 3: dot products, cross product, region
  logic signed [SW-1:0] s3_dot_a, s3_cross, s3_cross_abs;
  logic signed [TW-1:0] s3_dot_b;
  logic [CW-1:0]        s3_len2;
  logic [SW-1:0]        s3_ap2, s3_bp2;
  psd_tag_t             s3_tag;
  logic                 s3_mid;

  assign s3_dot_a = SW'(s2_abx_apx_q) + SW'(s2_aby_apy_q);
  assign s3_dot_b = TW'(0) - TW'(s2_abx_bpx_q) - TW'(s2_aby_bpy_q);
  assign s3_cross = SW'(s2_abx_apy_q) - SW'(s2_aby_apx_q);
  assign s3_cross_abs = s3_cross[SW-1] ? -s3_cross : s3_cross;
  assign s3_len2 = CW'($unsigned(s2_abx_sq_q)) + CW'($unsigned(s2_aby_sq_q));
  assign s3_ap2  = SW'($unsigned(s2_apx_sq_q)) + SW'($unsigned(s2_apy_sq_q));
  assign s3_bp2  = SW'($unsigned(s2_bpx_sq_q)) + SW'($unsigned(s2_bpy_sq_q));

  always_comb begin
    s3_tag.degen = s2_degen_q;
    s3_mid       = 1'b0;
    priority if (s2_degen_q) begin
      s3_tag.region = REGION_BETWEEN;
    end else if (!s3_dot_a[SW-1] && !s3_dot_b[TW-1]) begin
      s3_tag.region = REGION_BETWEEN;
      s3_mid        = 1'b1;
    end else if (s3_dot_a[SW-1]) begin
      s3_tag.region = REGION_BEFORE;
    end else begin
      s3_tag.region = REGION_BEYOND;
    end
  end

  logic          s3_vld_q, s3_mid_q;
  logic [CW-1:0] s3_c_q, s3_len2_q;
  logic [SW-1:0] s3_d2_q;
  psd_tag_t      s3_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (en_i) begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_c_q    <= s3_cross_abs[CW-1:0];
      s3_len2_q <= s3_len2;
      // end point distance: to A before A or when degenerate, else to B
      s3_d2_q   <= (s3_tag.region == REGION_BEYOND) ? s3_bp2 : s3_ap2;
      s3_mid_q  <= s3_mid;
      s3_tag_q  <= s3_tag;
    end
  end

  // stage 4: square of the cross product split in halves
  logic            s4_vld_q, s4_mid_q;
  logic [CW-1:0]   s4_hh_q, s4_hl_q, s4_ll_q, s4_len2_q;
  logic [SW-1:0]   s4_d2_q;
  psd_tag_t        s4_tag_q;
  logic [HW-1:0]   s4_ch, s4_cl;

  assign s4_ch = s3_c_q[CW-1:HW];
  assign s4_cl = s3_c_q[HW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else if (en_i) begin
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s4_hh_q   <= CW'(s4_ch) * CW'(s4_ch);
      s4_hl_q   <= CW'(s4_ch) * CW'(s4_cl);
      s4_ll_q   <= CW'(s4_cl) * CW'(s4_cl);
      s4_len2_q <= s3_len2_q;
      s4_d2_q   <= s3_d2_q;
      s4_mid_q  <= s3_mid_q;
      s4_tag_q  <= s3_tag_q;
    end
  end

  // stage 5: dividend and divisor; end point cases divide by one
  logic [2*CW-1:0] s5_csq;
  logic [NW-1:0]   s5_num;

  assign s5_csq = {s4_hh_q, s4_ll_q} + ((2*CW)'(s4_hl_q) << (HW + 1));
  assign s5_num = s4_mid_q ? (NW'(s5_csq) << (2 * FRAC_BITS))
                           : (NW'(s4_d2_q) << (2 * FRAC_BITS));

  logic          s5_vld_q;
  logic [LW-1:0] s5_rem_q, s5_div_q;
  logic [QW-1:0] s5_rest_q;
  psd_tag_t      s5_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_vld_q <= 1'b0;
    end else if (en_i) begin
      s5_vld_q <= s4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s5_rem_q  <= LW'(s5_num[NW-1:QW]);
      s5_rest_q <= s5_num[QW-1:0];
      s5_div_q  <= s4_mid_q ? s4_len2_q : LW'(1);
      s5_tag_q  <= s4_tag_q;
    end
  end

  assign valid_o = s5_vld_q;
  assign rem_o   = s5_rem_q;
  assign rest_o  = s5_rest_q;
  assign div_o   = s5_div_q;
  assign tag_o   = s5_tag_q;
endmodule
`default_nettype wire

### design/psd_div_cell.sv
// one restoring division cell: one quotient bit per cell
`default_nettype none
module psd_div_cell #(
  parameter int LW = 34,
  parameter int QW = 51
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire logic [LW-1:0]     rem_i,
  input  wire logic [QW-1:0]     rest_i,
  input  wire logic [LW-1:0]     div_i,
  input  wire psd_pkg::psd_tag_t tag_i,
  output logic                   valid_o,
  output logic [LW-1:0]          rem_o,
  output logic [QW-1:0]          rest_o,
  output logic [LW-1:0]          div_o,
  output psd_pkg::psd_tag_t      tag_o
);
  import psd_pkg::*;

  logic [LW:0]   r_sh, r_new;
  logic          ge;
  logic          vld_q;
  logic [LW-1:0] rem_q, div_q;
  logic [QW-1:0] rest_q;
  psd_tag_t      tag_q;

  assign r_sh  = {rem_i, rest_i[QW-1]};
  assign ge    = r_sh >= {1'b0, div_i};
  assign r_new = ge ? (r_sh - {1'b0, div_i}) : r_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= valid_i;
    end
  end

  // dividend bits leave at the top, quotient bits enter at the bottom
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= r_new[LW-1:0];
      rest_q <= {rest_i[QW-2:0], ge};
      div_q  <= div_i;
      tag_q  <= tag_i;
    end
  end

  assign valid_o = vld_q;
  assign rem_o   = rem_q;
  assign rest_o  = rest_q;
  assign div_o   = div_q;
  assign tag_o   = tag_q;
endmodule
`default_nettype wire

### design/psd_sqrt_cell.sv
// one digit-by-digit square root cell: one root bit per cell
`default_nettype none
module psd_sqrt_cell #(
  parameter int RW = 26
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire logic [RW+1:0]     rem_i,
  input  wire logic [RW-1:0]     root_i,
  input  wire logic [2*RW-1:0]   x_i,
  input  wire psd_pkg::psd_tag_t tag_i,
  output logic                   valid_o,
  output logic [RW+1:0]          rem_o,
  output logic [RW-1:0]          root_o,
  output logic [2*RW-1:0]        x_o,
  output psd_pkg::psd_tag_t      tag_o
);
  import psd_pkg::*;

  logic [RW+3:0]   r_sh, trial, r_new;
  logic            ge;
  logic            vld_q;
  logic [RW+1:0]   rem_q;
  logic [RW-1:0]   root_q;
  logic [2*RW-1:0] x_q;
  psd_tag_t        tag_q;

  assign r_sh  = {rem_i, x_i[2*RW-1:2*RW-2]};
  assign trial = {2'b00, root_i, 2'b01};
  assign ge    = r_sh >= trial;
  assign r_new = ge ? (r_sh - trial) : r_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= r_new[RW+1:0];
      root_q <= {root_i[RW-2:0], ge};
      x_q    <= x_i << 2;
      tag_q  <= tag_i;
    end
  end

  assign valid_o = vld_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign x_o     = x_q;
  assign tag_o   = tag_q;
endmodule
`default_nettype wire

### design/point_segment_distance_core.sv
// top level: front pipeline, divider and square root cell chains, output skid
//
// channel  dir  group                  contents
// in       in   s_axis_t{valid,ready}  tdata: px, py, ax, ay, bx, by_coord
// out      out  m_axis_t{valid,ready}  tdata: distance; tuser: region, degenerate
//
// one request per cycle while s_axis_tready is high; the QW cell divider chain
// (QW = 2*COORD_BITS + 3 + 2*FRAC_BITS) feeds the RW cell square root chain
// (RW = ceil(QW / 2)).
// reset clears only valid bits; no clearing pass.
// a stalled output fills a one-entry skid, after which s_axis_tready drops.
`default_nettype none
module point_segment_distance_core #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 8
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // px[15:0], py[31:16], ax[47:32], ay[63:48], bx[79:64], by_coord[95:80]
  input  wire logic [psd_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // distance[24:0], zeros[31:25]
  output logic [psd_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
  // region[1:0], degenerate[2]
  output logic [psd_pkg::USER_W-1:0]            m_axis_tuser
);
  import psd_pkg::*;

  localparam int LW = 2 * COORD_BITS + 2;
  localparam int QW = 2 * COORD_BITS + 3 + 2 * FRAC_BITS;
  localparam int RW = (QW + 1) / 2;
  localparam int XW = 2 * RW;

  logic en;

  // divider chain
  logic          dv_vld  [QW+1];
  logic [LW-1:0] dv_rem  [QW+1];
  logic [QW-1:0] dv_rest [QW+1];
  logic [LW-1:0] dv_div  [QW+1];
  psd_tag_t      dv_tag  [QW+1];

  psd_front #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(s_axis_tvalid),
    .px_i   ($signed(s_axis_tdata[1*IN_W-1:0*IN_W])),
    .py_i   ($signed(s_axis_tdata[2*IN_W-1:1*IN_W])),
    .ax_i   ($signed(s_axis_tdata[3*IN_W-1:2*IN_W])),
    .ay_i   ($signed(s_axis_tdata[4*IN_W-1:3*IN_W])),
    .bx_i   ($signed(s_axis_tdata[5*IN_W-1:4*IN_W])),
    .by_i   ($signed(s_axis_tdata[6*IN_W-1:5*IN_W])),
    .valid_o(dv_vld[0]),
    .rem_o  (dv_rem[0]),
    .rest_o (dv_rest[0]),
    .div_o  (dv_div[0]),
    .tag_o  (dv_tag[0])
  );

  for (genvar g = 0; g < QW; g++) begin : g_div
    psd_div_cell #(
      .LW(LW),
      .QW(QW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(dv_vld[g]),
      .rem_i  (dv_rem[g]),
      .rest_i (dv_rest[g]),
      .div_i  (dv_div[g]),
      .tag_i  (dv_tag[g]),
      .valid_o(dv_vld[g+1]),
      .rem_o  (dv_rem[g+1]),
      .rest_o (dv_rest[g+1]),
      .div_o  (dv_div[g+1]),
      .tag_o  (dv_tag[g+1])
    );
  end

  // square root chain, radicand is the quotient
  logic            sq_vld  [RW+1];
  logic [RW+1:0]   sq_rem  [RW+1];
  logic [RW-1:0]   sq_root [RW+1];
  logic [XW-1:0]   sq_x    [RW+1];
  psd_tag_t        sq_tag  [RW+1];

  assign sq_vld[0]  = dv_vld[QW];
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_x[0]    = XW'(dv_rest[QW]);
  assign sq_tag[0]  = dv_tag[QW];

  for (genvar g = 0; g < RW; g++) begin : g_sqrt
    psd_sqrt_cell #(
      .RW(RW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(sq_vld[g]),
      .rem_i  (sq_rem[g]),
      .root_i (sq_root[g]),
      .x_i    (sq_x[g]),
      .tag_i  (sq_tag[g]),
      .valid_o(sq_vld[g+1]),
      .rem_o  (sq_rem[g+1]),
      .root_o (sq_root[g+1]),
      .x_o    (sq_x[g+1]),
      .tag_o  (sq_tag[g+1])
    );
  end

  // saturate to the distance width
  logic [RW+DIST_W-1:0] root_ext;
  logic [DIST_W-1:0]    dist_sat;

  assign root_ext = (RW + DIST_W)'(sq_root[RW]);
  assign dist_sat = (|root_ext[RW+DIST_W-1:DIST_W]) ? '1 : root_ext[DIST_W-1:0];

  logic              res_vld_q;
  logic [DIST_W-1:0] res_dist_q;
  psd_tag_t          res_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (en) begin
      res_vld_q <= sq_vld[RW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_dist_q <= dist_sat;
      res_tag_q  <= sq_tag[RW];
    end
  end

  // output register with a one-entry skid
  logic              out_vld_q, skid_vld_q;
  logic [DIST_W-1:0] out_dist_q, skid_dist_q;
  psd_tag_t          out_tag_q, skid_tag_q;
  logic              pop, incoming;

  assign en       = !skid_vld_q;
  assign pop      = out_vld_q && m_axis_tready;
  assign incoming = en && res_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (pop) begin
        skid_vld_q <= 1'b0;
      end
    end else if (!out_vld_q || pop) begin
      out_vld_q <= incoming;
    end else if (incoming) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (pop) begin
        out_dist_q <= skid_dist_q;
        out_tag_q  <= skid_tag_q;
      end
    end else if (!out_vld_q || pop) begin
      if (incoming) begin
        out_dist_q <= res_dist_q;
        out_tag_q  <= res_tag_q;
      end
    end else if (incoming) begin
      skid_dist_q <= res_dist_q;
      skid_tag_q  <= res_tag_q;
    end
  end

  assign s_axis_tready = en;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OUT_DATA_W'(out_dist_q);
  assign m_axis_tuser  = {out_tag_q.degen, out_tag_q.region};
endmodule
`default_nettype wire

### design/psd_checker.sv
// port level checks for the point to segment distance core, bound to the top
`default_nettype none
module psd_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          s_axis_tvalid,
  input wire logic                          s_axis_tready,
  input wire logic [psd_pkg::IN_DATA_W-1:0] s_axis_tdata,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [psd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic [psd_pkg::USER_W-1:0]    m_axis_tuser
);
  import psd_pkg::*;

  logic unused_in;
  assign unused_in = s_axis_tvalid ^ s_axis_tready ^ (^s_axis_tdata);

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_region_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser[1:0] == REGION_BEFORE ||
                      m_axis_tuser[1:0] == REGION_BETWEEN ||
                      m_axis_tuser[1:0] == REGION_BEYOND)
    else $error("bad region code");

  a_degen_region: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1:0] == REGION_BETWEEN)
    else $error("degenerate segment outside middle region");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OUT_DATA_W-1:DIST_W] == '0)
    else $error("distance padding not zero");
endmodule

bind point_segment_distance_core psd_checker u_psd_checker (.*);
`default_nettype wire
